>>> rtl/bqe_pkg.sv
// Shared types and constants for the four-stage biquad equalizer.
package bqe_pkg;

   localparam int STAGE_COUNT   = 4;
   localparam int SAMPLE_WIDTH  = 24;
   localparam int COEF_WIDTH    = 32;
   localparam int HIST_WIDTH    = SAMPLE_WIDTH + 8;
   localparam int COEF_FRAC     = COEF_WIDTH - 8;
   localparam int GAIN_WIDTH    = 24;
   localparam int GAIN_FRAC     = 20;
   localparam int TAPS          = 5;
   localparam int TAP_BITS      = 3;
   localparam int STAGE_BITS    = 2;
   localparam int PROD_WIDTH    = COEF_WIDTH + HIST_WIDTH;
   localparam int ACC_WIDTH     = PROD_WIDTH + 3;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int CSR_WIDTH     = GAIN_WIDTH;

   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(1) << GAIN_FRAC;

   localparam logic [TAP_BITS-1:0] SEL_B0 = 3'd0;
   localparam logic [TAP_BITS-1:0] SEL_B1 = 3'd1;
   localparam logic [TAP_BITS-1:0] SEL_B2 = 3'd2;
   localparam logic [TAP_BITS-1:0] SEL_A1 = 3'd3;
   localparam logic [TAP_BITS-1:0] SEL_A2 = 3'd4;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_COEF   = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_BYPASS_MASK = 1'b0,
      CSR_MASTER_GAIN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                         command;
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic [STAGE_BITS-1:0]        coef_stage;
      logic [TAP_BITS-1:0]          coef_select;
      logic signed [COEF_WIDTH-1:0] coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [HIST_WIDTH-1:0] x1;
      logic signed [HIST_WIDTH-1:0] x2;
      logic signed [HIST_WIDTH-1:0] y1;
      logic signed [HIST_WIDTH-1:0] y2;
   } hist_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic gain_en;
      logic acc_clr;
      logic acc_en;
      logic round_en;
   } mac_ctrl_type;

endpackage

>>> rtl/bqe_store.sv
// Coefficient store and per-stage filter history.
module bqe_store #(
   parameter int STAGE_COUNT = bqe_pkg::STAGE_COUNT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  coef_we,
   input  logic [bqe_pkg::STAGE_BITS-1:0]        coef_stage,
   input  logic [bqe_pkg::TAP_BITS-1:0]          coef_select,
   input  logic signed [bqe_pkg::COEF_WIDTH-1:0] coef_value,
   input  logic [((STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1)-1:0] rd_stage,
   input  logic [bqe_pkg::TAP_BITS-1:0]          rd_tap,
   input  logic                                  hist_we,
   input  logic signed [bqe_pkg::HIST_WIDTH-1:0] x_new,
   input  logic signed [bqe_pkg::HIST_WIDTH-1:0] y_new,
   output logic signed [bqe_pkg::COEF_WIDTH-1:0] coef_rd,
   output bqe_pkg::hist_type                     hist
);

   localparam int SIW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   logic signed [bqe_pkg::COEF_WIDTH-1:0] coef_ff [STAGE_COUNT][bqe_pkg::TAPS];
   bqe_pkg::hist_type hist_ff [STAGE_COUNT];
   logic [SIW-1:0] wr_stage;
   logic           wr_ok;

   assign wr_stage = SIW'(coef_stage);
   assign wr_ok    = (int'(coef_stage) < STAGE_COUNT) && (int'(coef_select) < bqe_pkg::TAPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGE_COUNT; s++) begin
            for (int t = 0; t < bqe_pkg::TAPS; t++) begin
               coef_ff[s][t] <= '0;
            end
         end
      end else if (coef_we && wr_ok) begin
         coef_ff[wr_stage][coef_select] <= coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGE_COUNT; s++) begin
            hist_ff[s] <= '0;
         end
      end else if (hist_we) begin
         hist_ff[rd_stage].x2 <= hist_ff[rd_stage].x1;
         hist_ff[rd_stage].x1 <= x_new;
         hist_ff[rd_stage].y2 <= hist_ff[rd_stage].y1;
         hist_ff[rd_stage].y1 <= y_new;
      end
   end

   assign coef_rd = coef_ff[rd_stage][rd_tap];
   assign hist    = hist_ff[rd_stage];

endmodule

>>> rtl/bqe_mac_unit.sv
// Shared multiply-accumulate unit with rounding and saturation.
module bqe_mac_unit (
   input  logic                                    clock,
   input  bqe_pkg::mac_ctrl_type                   ctrl,
   input  logic [bqe_pkg::TAP_BITS-1:0]            tap,
   input  logic signed [bqe_pkg::SAMPLE_WIDTH-1:0] sample_in,
   input  logic [bqe_pkg::GAIN_WIDTH-1:0]          master_gain,
   input  logic signed [bqe_pkg::COEF_WIDTH-1:0]   coef_rd,
   input  bqe_pkg::hist_type                       hist,
   output logic signed [bqe_pkg::HIST_WIDTH-1:0]   x_cur,
   output logic signed [bqe_pkg::HIST_WIDTH-1:0]   y_new,
   output bqe_pkg::rsp_type                        result
);

   localparam int HW  = bqe_pkg::HIST_WIDTH;
   localparam int CW  = bqe_pkg::COEF_WIDTH;
   localparam int PW  = bqe_pkg::PROD_WIDTH;
   localparam int AW  = bqe_pkg::ACC_WIDTH;
   localparam int SW  = bqe_pkg::SAMPLE_WIDTH;
   localparam int CF  = bqe_pkg::COEF_FRAC;
   localparam int GF  = bqe_pkg::GAIN_FRAC;

   logic signed [HW-1:0] value_ff, value_in;
   logic                 clip_ff, clip_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic [AW-1:0]        acc_ff, acc_in;

   logic signed [HW-1:0] operand;
   logic signed [CW-1:0] mul_a;
   logic signed [HW-1:0] mul_b;
   logic [AW-1:0]        prod_ext;
   logic [AW-1:0]        rnd;
   logic [AW-HW-CF:0]    rnd_top;
   logic                 stage_fit;
   logic [PW-1:0]        frnd;
   logic [PW-SW-GF:0]    frnd_top;
   logic                 final_fit;

   always_comb begin
      case (tap)
         bqe_pkg::SEL_B0: operand = value_ff;
         bqe_pkg::SEL_B1: operand = hist.x1;
         bqe_pkg::SEL_B2: operand = hist.x2;
         bqe_pkg::SEL_A1: operand = hist.y1;
         bqe_pkg::SEL_A2: operand = hist.y2;
         default:         operand = '0;
      endcase
   end

   assign neg_in  = (tap == bqe_pkg::SEL_A1) || (tap == bqe_pkg::SEL_A2);
   assign mul_a   = ctrl.gain_en ? $signed({{(CW - bqe_pkg::GAIN_WIDTH){1'b0}}, master_gain})
                                 : coef_rd;
   assign mul_b   = ctrl.gain_en ? value_ff : operand;
   assign prod_in = mul_a * mul_b;

   assign prod_ext = {{(AW - PW){prod_ff[PW-1]}}, prod_ff};
   assign acc_in   = ctrl.acc_clr ? '0 : (neg_ff ? acc_ff - prod_ext : acc_ff + prod_ext);

   // stage output: round half up by the coefficient fraction, saturate to history width
   assign rnd       = acc_ff + (AW'(1) << (CF - 1));
   assign rnd_top   = rnd[AW-1:CF+HW-1];
   assign stage_fit = (&rnd_top) || !(|rnd_top);
   assign y_new     = stage_fit ? rnd[CF+HW-1:CF]
                    : (rnd[AW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}});

   assign value_in = ctrl.load ? {{(HW - SW){sample_in[SW-1]}}, sample_in}
                   : (ctrl.round_en ? y_new : value_ff);
   assign clip_in  = ctrl.load ? 1'b0 : (clip_ff | (ctrl.round_en & !stage_fit));

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      clip_ff  <= clip_in;
      if (ctrl.mul_en || ctrl.gain_en) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
      if (ctrl.acc_clr || ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // master gain: round half up by the gain fraction, saturate to sample width
   assign frnd      = prod_ff + (PW'(1) << (GF - 1));
   assign frnd_top  = frnd[PW-1:GF+SW-1];
   assign final_fit = (&frnd_top) || !(|frnd_top);

   assign result.sample_out = final_fit ? frnd[GF+SW-1:GF]
                            : (frnd[PW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});
   assign result.clipped    = clip_ff | !final_fit;
   assign x_cur             = value_ff;

endmodule

>>> rtl/bqe_sequencer.sv
// Sequencer that steps the shared MAC unit through stages and taps.
module bqe_sequencer #(
   parameter int STAGE_COUNT = bqe_pkg::STAGE_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_command,
   input  logic [STAGE_COUNT-1:0]           bypass_mask,
   input  logic                             rsp_busy,
   output logic                             req_ready,
   output logic                             coef_we,
   output logic                             rsp_load,
   output bqe_pkg::mac_ctrl_type            ctrl,
   output logic [((STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1)-1:0] rd_stage,
   output logic [bqe_pkg::TAP_BITS-1:0]     tap
);

   localparam int SIW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
   localparam int SCW = $clog2(STAGE_COUNT + 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_MAC   = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_GAIN  = 7'b0100000,
      ST_FINAL = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [SCW-1:0]                stage_ff, stage_in;
   logic [bqe_pkg::TAP_BITS-1:0]  tap_ff, tap_in;

   assign rd_stage = stage_ff[SIW-1:0];
   assign tap      = tap_ff;

   always_comb begin
      state_in  = state_ff;
      stage_in  = stage_ff;
      tap_in    = tap_ff;
      req_ready = 1'b0;
      coef_we   = 1'b0;
      rsp_load  = 1'b0;
      ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == bqe_pkg::CMD_COEF) begin
                  coef_we = 1'b1;
               end else begin
                  ctrl.load = 1'b1;
                  stage_in  = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (int'(stage_ff) == STAGE_COUNT) begin
               state_in = ST_GAIN;
            end else if (bypass_mask[rd_stage]) begin
               stage_in = stage_ff + SCW'(1);
            end else begin
               ctrl.acc_clr = 1'b1;
               tap_in       = bqe_pkg::SEL_B0;
               state_in     = ST_MAC;
            end
         end
         ST_MAC: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_en = (tap_ff != bqe_pkg::SEL_B0);
            if (tap_ff == bqe_pkg::SEL_A2) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            ctrl.acc_en = 1'b1;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            ctrl.round_en = 1'b1;
            stage_in      = stage_ff + SCW'(1);
            state_in      = ST_SCAN;
         end
         ST_GAIN: begin
            ctrl.gain_en = 1'b1;
            state_in     = ST_FINAL;
         end
         ST_FINAL: begin
            if (!rsp_busy) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

>>> rtl/four_stage_biquad_equalizer_top.sv
// Top level of the four-stage biquad equalizer.
// A coefficient write is taken while idle and leaves the block ready. A sample runs
// through each active stage in turn (scan, five taps, drain, round; a bypassed stage is
// only scanned), then the master gain; the next item is taken only once the result is
// loaded, which waits while the output stalls. It all uses one shared 32x32 multiplier.
// Reset is synchronous: coefficients and history clear, all stages bypassed, gain 1.0.
module four_stage_biquad_equalizer_top #(
   parameter int STAGE_COUNT = bqe_pkg::STAGE_COUNT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bqe_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bqe_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [bqe_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [bqe_pkg::CSR_WIDTH-1:0]        csr_wdata
);

   localparam int SIW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   logic [STAGE_COUNT-1:0]             bypass_ff, bypass_in;
   logic [bqe_pkg::GAIN_WIDTH-1:0]     gain_ff, gain_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   bqe_pkg::rsp_type                   rsp_ff;

   bqe_pkg::mac_ctrl_type              ctrl;
   logic [SIW-1:0]                     rd_stage;
   logic [bqe_pkg::TAP_BITS-1:0]       tap;
   logic                               coef_we;
   logic                               rsp_load;
   logic                               rsp_busy;
   logic signed [bqe_pkg::COEF_WIDTH-1:0] coef_rd;
   bqe_pkg::hist_type                  hist;
   logic signed [bqe_pkg::HIST_WIDTH-1:0] x_cur;
   logic signed [bqe_pkg::HIST_WIDTH-1:0] y_new;
   bqe_pkg::rsp_type                   result;

   always_comb begin
      bypass_in = bypass_ff;
      gain_in   = gain_ff;
      if (csr_we) begin
         case (bqe_pkg::csr_index_type'(csr_index))
            bqe_pkg::CSR_BYPASS_MASK: bypass_in = csr_wdata[STAGE_COUNT-1:0];
            bqe_pkg::CSR_MASTER_GAIN: gain_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_busy     = rsp_valid_ff && !rsp_ready;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff    <= '1;
         gain_ff      <= bqe_pkg::GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bypass_ff    <= bypass_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   bqe_sequencer #(
      .STAGE_COUNT(STAGE_COUNT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .bypass_mask (bypass_ff),
      .rsp_busy    (rsp_busy),
      .req_ready   (req_ready),
      .coef_we     (coef_we),
      .rsp_load    (rsp_load),
      .ctrl        (ctrl),
      .rd_stage    (rd_stage),
      .tap         (tap)
   );

   bqe_store #(
      .STAGE_COUNT(STAGE_COUNT)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .coef_we     (coef_we),
      .coef_stage  (req_data.coef_stage),
      .coef_select (req_data.coef_select),
      .coef_value  (req_data.coef_value),
      .rd_stage    (rd_stage),
      .rd_tap      (tap),
      .hist_we     (ctrl.round_en),
      .x_new       (x_cur),
      .y_new       (y_new),
      .coef_rd     (coef_rd),
      .hist        (hist)
   );

   bqe_mac_unit u_mac (
      .clock       (clock),
      .ctrl        (ctrl),
      .tap         (tap),
      .sample_in   (req_data.sample_in),
      .master_gain (gain_ff),
      .coef_rd     (coef_rd),
      .hist        (hist),
      .x_cur       (x_cur),
      .y_new       (y_new),
      .result      (result)
   );

endmodule

>>> rtl/bqe_checker.sv
// Port-level checks for the equalizer top level, bound to it.
module bqe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bqe_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bqe_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item dropped or changed while stalled");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == bqe_pkg::CMD_SAMPLE) |=> !req_ready)
      else $error("ready stayed high after a sample item");

   a_coef_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == bqe_pkg::CMD_COEF) |=> req_ready)
      else $error("coefficient item left the block busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp item appeared without a sample in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind four_stage_biquad_equalizer_top bqe_checker u_bqe_checker (.*);

>>> tb/four_stage_biquad_equalizer_checker.sv
// Equalizer checker: predicts each processed item from accepted inputs and compares outputs.
`timescale 1ns / 100ps

module four_stage_biquad_equalizer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  bqe_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  bqe_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [bqe_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [bqe_pkg::CSR_WIDTH-1:0]     csr_wdata,
   output int                                outstanding,
   output int                                failures
);
   import bqe_pkg::*;

   typedef logic signed [79:0] wide_int;

   logic signed [COEF_WIDTH-1:0] coef_bank [STAGE_COUNT*TAPS];
   logic signed [HIST_WIDTH-1:0] in_z1 [STAGE_COUNT];
   logic signed [HIST_WIDTH-1:0] in_z2 [STAGE_COUNT];
   logic signed [HIST_WIDTH-1:0] out_z1 [STAGE_COUNT];
   logic signed [HIST_WIDTH-1:0] out_z2 [STAGE_COUNT];
   logic [STAGE_COUNT-1:0]       bypass_mask;
   logic [GAIN_WIDTH-1:0]        gain_reg;
   bit                           clip_seen;
   rsp_type                      equalized_q [$];
   int                           output_count;

   initial failures = 0;

   task automatic flag_mismatch(input string what);
      $display("%0t: %s", $time, what);
      failures++;
   endtask

   function automatic wide_int round_clamp(input wide_int v, input int frac, input int width);
      wide_int half, hi_lim, lo_lim, r;
      half = 1;
      half = half <<< (frac - 1);
      hi_lim = 1;
      hi_lim = (hi_lim <<< (width - 1)) - 1;
      lo_lim = -hi_lim - 1;
      r = (v + half) >>> frac;
      if (r > hi_lim) begin
         clip_seen = 1'b1;
         r = hi_lim;
      end else if (r < lo_lim) begin
         clip_seen = 1'b1;
         r = lo_lim;
      end
      return r;
   endfunction

   function automatic wide_int run_biquad(input int st, input wide_int x);
      wide_int b0, b1, b2, a1, a2, x1, x2, y1, y2, acc, y;
      b0 = coef_bank[st*TAPS + SEL_B0];
      b1 = coef_bank[st*TAPS + SEL_B1];
      b2 = coef_bank[st*TAPS + SEL_B2];
      a1 = coef_bank[st*TAPS + SEL_A1];
      a2 = coef_bank[st*TAPS + SEL_A2];
      x1 = in_z1[st];
      x2 = in_z2[st];
      y1 = out_z1[st];
      y2 = out_z2[st];
      acc = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2;
      y = round_clamp(acc, COEF_FRAC, HIST_WIDTH);
      in_z2[st] = in_z1[st];
      in_z1[st] = x[HIST_WIDTH-1:0];
      out_z2[st] = out_z1[st];
      out_z1[st] = y[HIST_WIDTH-1:0];
      return y;
   endfunction

   function automatic rsp_type equalize(input logic signed [SAMPLE_WIDTH-1:0] smp);
      wide_int v, g;
      rsp_type r;
      int st;
      clip_seen = 1'b0;
      v = smp;
      for (st = 0; st < STAGE_COUNT; st++)
         if (!bypass_mask[st])
            v = run_biquad(st, v);
      g = gain_reg;
      v = round_clamp(v * g, GAIN_FRAC, SAMPLE_WIDTH);
      r.sample_out = v[SAMPLE_WIDTH-1:0];
      r.clipped = clip_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < STAGE_COUNT*TAPS; i++)
            coef_bank[i] = '0;
         for (int i = 0; i < STAGE_COUNT; i++) begin
            in_z1[i] = '0;
            in_z2[i] = '0;
            out_z1[i] = '0;
            out_z2[i] = '0;
         end
         bypass_mask = '1;
         gain_reg = GAIN_RESET;
         equalized_q.delete();
         output_count = 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_BYPASS_MASK: bypass_mask = csr_wdata[STAGE_COUNT-1:0];
               CSR_MASTER_GAIN: gain_reg = csr_wdata[GAIN_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (equalized_q.size() == 0) begin
               flag_mismatch($sformatf("output %0d: no item expected", output_count));
            end else begin
               want = equalized_q.pop_front();
               if (rsp_data.sample_out !== want.sample_out)
                  flag_mismatch($sformatf("output %0d: sample_out expected %0d got %0d",
                     output_count, want.sample_out, rsp_data.sample_out));
               if (rsp_data.clipped !== want.clipped)
                  flag_mismatch($sformatf("output %0d: clipped expected %0b got %0b",
                     output_count, want.clipped, rsp_data.clipped));
            end
            output_count++;
         end
         if (req_valid && req_ready) begin
            if (req_data.command == CMD_COEF) begin
               if (req_data.coef_stage < STAGE_COUNT && req_data.coef_select <= SEL_A2)
                  coef_bank[req_data.coef_stage*TAPS + req_data.coef_select] =
                     req_data.coef_value;
            end else begin
               equalized_q.push_back(equalize(req_data.sample_in));
            end
         end
         outstanding <= equalized_q.size();
      end
   end

endmodule

>>> tb/four_stage_biquad_equalizer_top_tb.sv
// Testbench top: drives samples, coefficient writes and register settings, reports verdict.
`timescale 1ns / 100ps

module four_stage_biquad_equalizer_top_tb;
   import bqe_pkg::*;

   localparam int IDLE_PCT    = 31;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 230;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_we;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]     csr_wdata;
   int                       idle_pct;
   int                       outstanding;
   int                       failures;

   four_stage_biquad_equalizer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   four_stage_biquad_equalizer_checker response_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   function automatic req_type sample_item(input logic signed [SAMPLE_WIDTH-1:0] smp);
      logic [63:0] noise;
      req_type it;
      noise = {$urandom, $urandom};
      it = noise[$bits(req_type)-1:0];
      it.command = CMD_SAMPLE;
      it.sample_in = smp;
      return it;
   endfunction

   function automatic req_type coef_item(input int stage, input logic [TAP_BITS-1:0] sel,
                                         input logic [COEF_WIDTH-1:0] value);
      logic [63:0] noise;
      req_type it;
      noise = {$urandom, $urandom};
      it = noise[$bits(req_type)-1:0];
      it.command = CMD_COEF;
      it.coef_stage = STAGE_BITS'(stage);
      it.coef_select = sel;
      it.coef_value = value;
      return it;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      logic signed [SAMPLE_WIDTH-1:0] s;
      s = SAMPLE_WIDTH'($urandom);
      case ($urandom_range(9))
         0: s = s[SAMPLE_WIDTH-1] ? 24'sh800000 : 24'sh7FFFFF;
         1, 2: ;
         default: s = s >>> $urandom_range(1, 8);
      endcase
      return s;
   endfunction

   // mostly near-stable Q8.24 values, sometimes anything
   function automatic logic [COEF_WIDTH-1:0] random_coef(input logic [TAP_BITS-1:0] sel);
      int lim;
      if ($urandom_range(9) == 0)
         return $urandom;
      lim = (sel == SEL_A1) ? 31876710 : (sel == SEL_A2) ? 15938355 : 25165824;
      return $urandom_range(2 * lim) - lim;
   endfunction

   task automatic send_item(input req_type item);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic program_registers(input logic [STAGE_COUNT-1:0] mask,
                                    input logic [GAIN_WIDTH-1:0] gain);
      logic [CSR_WIDTH-1:0] word;
      word = CSR_WIDTH'($urandom);
      word[STAGE_COUNT-1:0] = mask;
      csr_we <= 1'b1;
      csr_index <= CSR_BYPASS_MASK;
      csr_wdata <= word;
      @(posedge clock);
      csr_index <= CSR_MASTER_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int sent, st, sel, pick;
      sent = 0;
      for (st = 0; st < STAGE_COUNT; st++) begin
         if ($urandom_range(1) == 1) begin
            for (sel = SEL_B0; sel <= SEL_A2; sel++) begin
               send_item(coef_item(st, TAP_BITS'(sel), random_coef(TAP_BITS'(sel))));
               sent++;
            end
         end
      end
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_item(sample_item(random_sample()));
            sent++;
         end else if (pick < 94) begin
            sel = $urandom_range(SEL_B0, SEL_A2);
            send_item(coef_item($urandom_range(STAGE_COUNT - 1), TAP_BITS'(sel),
               random_coef(TAP_BITS'(sel))));
            sent++;
         end else begin
            send_item(coef_item($urandom_range(STAGE_COUNT - 1),
               TAP_BITS'($urandom_range(SEL_A2 + 1, (1 << TAP_BITS) - 1)), $urandom));
            sent++;
         end
      end
   endtask

   initial begin
      #8_000_000;
      $display("four_stage_biquad_equalizer_top_tb: done, errors");
      $finish;
   end

   initial begin
      int p;
      logic [STAGE_COUNT-1:0] mask;
      logic [GAIN_WIDTH-1:0] gain;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_BYPASS_MASK;
      csr_wdata <= '0;
      idle_pct <= IDLE_PCT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all stages bypassed, unity gain
      send_item(sample_item(24'sh7FFFFF));
      send_item(sample_item(24'sh800000));
      send_item(sample_item(24'sh000000));
      send_item(sample_item(24'shFFFFFF));
      send_item(coef_item(0, SEL_B0, 32'h0100_0000));
      send_item(coef_item(0, SEL_A2 + 3'd1, 32'h7FFF_FFFF));
      send_item(coef_item(0, '1, 32'h8000_0000));
      send_item(coef_item(1, SEL_B0, 32'h7FFF_FFFF));
      send_item(sample_item(24'sh400000));
      send_item(coef_item(1, SEL_A1, 32'h8000_0000));
      send_item(coef_item(2, SEL_B1, 32'h0080_0000));
      send_item(coef_item(3, SEL_A2, 32'hFF00_0000));
      settle();

      program_registers('0, '1);
      send_item(sample_item(24'sh7FFFFF));
      send_item(sample_item(24'sh800000));
      send_item(sample_item(24'sh000001));
      settle();

      program_registers(4'b1010, '0);
      send_item(sample_item(24'sh7FFFFF));
      send_item(sample_item(24'sh003039));
      settle();

      program_registers('1, '1);
      send_item(sample_item(24'shFFFFFF));
      send_item(sample_item(24'sh000001));
      send_item(sample_item(24'sh7FFFFF));
      settle();

      for (p = 0; p < PHASES; p++) begin
         mask = STAGE_COUNT'($urandom);
         gain = GAIN_WIDTH'(($urandom_range(3) == 0) ? $urandom
                                                     : $urandom_range(24'h1FFFFF));
         case (p)
            0: mask = '0;
            1: mask = '1;
            2: gain = '1;
            3: gain = '0;
            4: gain = GAIN_RESET;
            default: ;
         endcase
         idle_pct <= (p == 5) ? 0 : IDLE_PCT;
         program_registers(mask, gain);
         random_phase(PHASE_ITEMS);
         settle();
      end

      if (failures == 0 && outstanding == 0)
         $display("four_stage_biquad_equalizer_top_tb: done, clean");
      else
         $display("four_stage_biquad_equalizer_top_tb: done, errors");
      $finish;
   end

endmodule
